@@ rtl/core/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the stable priority queue
// Entry layout, action codes and the control bundle broadcast to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned PRIO_W = 8;
	localparam int unsigned PAY_W  = 16;
	localparam int unsigned OCC_W  = 5;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POP  = 1'b1
	} action_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  payload;
	} entry_t;

	// Broadcast to all cells in the cycle a transfer is taken.
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t entry;
	} cell_ctrl_t;

endpackage

@@ rtl/core/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one storage cell of the sorted queue
// Holds one entry and either keeps it, takes the new entry, or takes the
// entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  logic                left_stay,
	input  spq_pkg::entry_t     left_entry,
	input  spq_pkg::entry_t     right_entry,
	output logic                stay,
	output spq_pkg::entry_t     entry
);

	spq_pkg::entry_t entry_q;

	// An occupied cell whose priority is not above the new one keeps its place,
	// which keeps arrivals of equal priority in order.
	assign stay  = occupied && (entry_q.prio <= ctrl.entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (!stay) begin
				if (left_stay) begin
					entry_q <= ctrl.entry;
				end else begin
					entry_q <= left_entry;
				end
			end
		end else if (ctrl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ rtl/core/stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded sorted priority queue
// A row of cells kept in priority order; equal priorities leave first in,
// first out. Push to a full queue is rejected, pop from empty returns nothing.
// ----------------------------------------------------------------------------
// An input transfer's result is registered and appears in the next cycle.
// Throughput: one item per cycle; every cell compares and shifts in parallel.
// A waiting result holds off the input; the next item enters in the cycle
// that result leaves.
// Reset clears the count and the output handshake; cell contents are not reset
// and only cells below the count are ever read.
module stable_priority_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [0:0]  action,
	input  logic [7:0]  priority_req,
	input  logic [15:0] payload,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        out_valid,
	output logic [7:0]  out_priority,
	output logic [15:0] out_payload,
	output logic        rejected,
	output logic [4:0]  occupancy
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_next;
	logic [CW+4:0]       occ_ext;
	logic                in_fire;
	logic                is_push;
	logic                full;
	logic                empty;
	spq_pkg::cell_ctrl_t ctrl;
	spq_pkg::entry_t     cell_entry [DEPTH];
	logic                cell_stay  [DEPTH];

	logic                res_valid_q;
	logic                out_valid_q;
	logic [7:0]          out_priority_q;
	logic [15:0]         out_payload_q;
	logic                rejected_q;
	logic [4:0]          occupancy_q;

	assign in_ready = !res_valid_q || res_ready;
	assign in_fire  = in_valid && in_ready;
	assign is_push  = (action == spq_pkg::ACT_PUSH);
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	assign ctrl.push          = in_fire && is_push && !full;
	assign ctrl.pop           = in_fire && !is_push && !empty;
	assign ctrl.entry.prio    = priority_req;
	assign ctrl.entry.payload = payload;

	always_comb begin
		count_next = count_q;
		if (ctrl.push) begin
			count_next = count_q + CW'(1);
		end else if (ctrl.pop) begin
			count_next = count_q - CW'(1);
		end
	end

	assign occ_ext = {5'b0, count_next};

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic            left_stay_w;
			spq_pkg::entry_t left_w;
			spq_pkg::entry_t right_w;

			if (gi == 0) begin : g_head
				assign left_stay_w = 1'b1;
				assign left_w      = ctrl.entry;
			end else begin : g_body
				assign left_stay_w = cell_stay[gi-1];
				assign left_w      = cell_entry[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign right_w = '0;
			end else begin : g_inner
				assign right_w = cell_entry[gi+1];
			end

			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occupied    (count_q > CW'(gi)),
				.left_stay   (left_stay_w),
				.left_entry  (left_w),
				.right_entry (right_w),
				.stay        (cell_stay[gi]),
				.entry       (cell_entry[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (in_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// The head cell still holds the popped entry during the transfer cycle.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_valid_q    <= ctrl.pop;
			out_priority_q <= ctrl.pop ? cell_entry[0].prio : 8'd0;
			out_payload_q  <= ctrl.pop ? cell_entry[0].payload : 16'd0;
			rejected_q     <= is_push && full;
			occupancy_q    <= occ_ext[4:0];
		end
	end

	assign res_valid    = res_valid_q;
	assign out_valid    = out_valid_q;
	assign out_priority = out_priority_q;
	assign out_payload  = out_payload_q;
	assign rejected     = rejected_q;
	assign occupancy    = occupancy_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(out_valid_q && rejected_q))
		else $error("result both popped and rejected");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && is_push && full) |=> $stable(count_q))
		else $error("rejected push changed the count");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
		else $error("head cells out of order");

endmodule

@@ dv/spq_order_checker.sv @@
// ----------------------------------------------------------------------------
// spq_order_checker: ordering checker for the stable priority queue
// Watches both channels, keeps its own sorted copy of the queue contents and
// compares every result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module spq_order_checker #(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [0:0]  action,
	input  logic [7:0]  priority_req,
	input  logic [15:0] payload,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic        out_valid,
	input  logic [7:0]  out_priority,
	input  logic [15:0] out_payload,
	input  logic        rejected,
	input  logic [4:0]  occupancy,
	output int          outstanding,
	output int          mismatches,
	output int          push_total,
	output int          reject_total,
	output int          pop_total,
	output int          empty_pop_total,
	output int          peak_held
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                       valid;
		logic [spq_pkg::PRIO_W-1:0] prio;
		logic [spq_pkg::PAY_W-1:0]  pay;
		logic                       rejected;
		logic [spq_pkg::OCC_W-1:0]  occ;
	} pq_result_t;

	spq_pkg::entry_t sorted [DEPTH];
	int              held;
	pq_result_t      awaited_results [$];
	int              n_bad, n_checked;
	int              n_push, n_reject, n_pop, n_empty, n_peak;

	task automatic report_mismatch(input string what, input int unsigned want,
			input logic [31:0] got);
		$display("[%0t] result %0d: %s expected %0h, got %0h",
			$time, n_checked, what, want, got);
		n_bad++;
	endtask

	// Sorted insertion: a new entry goes behind every entry of equal or lower
	// priority number, which keeps equal priorities in arrival order.
	task automatic queue_step(input spq_pkg::action_t act, input logic [7:0] prio,
			input logic [15:0] pay, output pq_result_t r);
		int pos;
		r = '0;
		if (act == spq_pkg::ACT_PUSH) begin
			n_push++;
			if (held >= DEPTH) begin
				r.rejected = 1'b1;
				n_reject++;
			end else begin
				pos = 0;
				while (pos < held && sorted[pos].prio <= prio)
					pos++;
				for (int i = held; i > pos; i--)
					sorted[i] = sorted[i-1];
				sorted[pos] = {prio, pay};
				held++;
			end
		end else begin
			n_pop++;
			if (held == 0) begin
				n_empty++;
			end else begin
				r.valid = 1'b1;
				r.prio  = sorted[0].prio;
				r.pay   = sorted[0].payload;
				for (int i = 1; i < held; i++)
					sorted[i-1] = sorted[i];
				held--;
			end
		end
		if (held > n_peak)
			n_peak = held;
		r.occ = spq_pkg::OCC_W'(held);
	endtask

	task automatic check_result();
		pq_result_t want;
		n_checked++;
		if (awaited_results.size() == 0) begin
			report_mismatch("result with nothing outstanding", 0, 0);
			return;
		end
		want = awaited_results.pop_front();
		if (out_valid !== want.valid)
			report_mismatch("out_valid", want.valid, out_valid);
		if (out_priority !== want.prio)
			report_mismatch("out_priority", want.prio, out_priority);
		if (out_payload !== want.pay)
			report_mismatch("out_payload", want.pay, out_payload);
		if (rejected !== want.rejected)
			report_mismatch("rejected", want.rejected, rejected);
		if (occupancy !== want.occ)
			report_mismatch("occupancy", want.occ, occupancy);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pq_result_t r;
		if (!arst_n) begin
			held = 0;
			awaited_results.delete();
			n_bad = 0;
			n_checked = 0;
			n_push = 0;
			n_reject = 0;
			n_pop = 0;
			n_empty = 0;
			n_peak = 0;
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			// A result leaving now always belongs to an earlier input transfer.
			if (res_valid && res_ready)
				check_result();
			if (in_valid && in_ready) begin
				queue_step(spq_pkg::action_t'(action), priority_req, payload, r);
				awaited_results.push_back(r);
			end
			outstanding     <= awaited_results.size();
			mismatches      <= n_bad;
			push_total      <= n_push;
			reject_total    <= n_reject;
			pop_total       <= n_pop;
			empty_pop_total <= n_empty;
			peak_held       <= n_peak;
		end
	end

endmodule

@@ dv/tb_stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// tb_stable_priority_queue: testbench for the stable priority queue
// Drives a directed fill and six pops, then random push and pop mixes under
// changing back-pressure, including a long receiver hold-off; the checker
// beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH     = 16;
	localparam int          HOLD_LEN  = 60;
	localparam int          CYCLE_CAP = 300000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [0:0]  action;
	logic [7:0]  priority_req;
	logic [15:0] payload;
	logic        res_valid;
	logic        res_ready;
	logic        out_valid;
	logic [7:0]  out_priority;
	logic [15:0] out_payload;
	logic        rejected;
	logic [4:0]  occupancy;

	int outstanding, mismatches;
	int push_total, reject_total, pop_total, empty_pop_total, peak_held;
	int send_idle_pct;
	int recv_idle_pct;
	logic hold_go;
	int cycles = 0;

	stable_priority_queue #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.priority_req(priority_req),
		.payload(payload),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_valid(out_valid),
		.out_priority(out_priority),
		.out_payload(out_payload),
		.rejected(rejected),
		.occupancy(occupancy)
	);

	spq_order_checker #(.DEPTH(DEPTH)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.priority_req(priority_req),
		.payload(payload),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_valid(out_valid),
		.out_priority(out_priority),
		.out_payload(out_payload),
		.rejected(rejected),
		.occupancy(occupancy),
		.outstanding(outstanding),
		.mismatches(mismatches),
		.push_total(push_total),
		.reject_total(reject_total),
		.pop_total(pop_total),
		.empty_pop_total(empty_pop_total),
		.peak_held(peak_held)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("Run stopped at the cycle limit with %0d results outstanding",
				outstanding);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off once requested.
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 0;
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_taken) begin
				hold_taken = 1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Valid stays high across back-to-back transfers; it only drops for a gap.
	task automatic offer_item(input spq_pkg::action_t act, input logic [7:0] prio,
			input logic [15:0] pay);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		priority_req <= prio;
		payload      <= pay;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Mostly a few nearby priorities so ties are common, plus the extremes.
	function automatic logic [7:0] pick_priority();
		int sel;
		sel = $urandom_range(9);
		if (sel < 4)
			return 8'($urandom_range(3));
		else if (sel == 4)
			return 8'd0;
		else if (sel == 5)
			return 8'd255;
		else
			return 8'($urandom_range(255));
	endfunction

	// Push share changes every few dozen items so occupancy sweeps empty to full.
	task automatic run_mix(input int n);
		int push_pct;
		push_pct = 50;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				push_pct = $urandom_range(15, 85);
			if ($urandom_range(99) < push_pct)
				offer_item(spq_pkg::ACT_PUSH, pick_priority(), 16'($urandom));
			else
				offer_item(spq_pkg::ACT_POP, 8'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		static logic [23:0] fill_set [16] = '{
			24'hFF_0000, 24'h00_FFFF, 24'h07_0001, 24'h07_0002,
			24'h07_0003, 24'hFF_FFFF, 24'h00_0000, 24'h80_8000,
			24'h7F_7FFF, 24'h07_0004, 24'h01_AAAA, 24'hFE_5555,
			24'h80_1234, 24'h00_00FF, 24'hFF_FF00, 24'h40_4321
		};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= spq_pkg::ACT_PUSH;
		priority_req <= '0;
		payload <= '0;
		hold_go <= 1'b0;
		send_idle_pct = 8;
		recv_idle_pct <= 48;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pop on empty, fill with ties and extremes, push on full.
		offer_item(spq_pkg::ACT_POP, 8'hFF, 16'hFFFF);
		foreach (fill_set[i])
			offer_item(spq_pkg::ACT_PUSH, fill_set[i][23:16], fill_set[i][15:0]);
		offer_item(spq_pkg::ACT_PUSH, 8'h03, 16'hBEEF);
		repeat (6)
			offer_item(spq_pkg::ACT_POP, 8'h00, 16'h0000);

		run_mix(370);

		send_idle_pct = 48;
		recv_idle_pct <= 8;
		run_mix(370);

		// Long receiver hold-off while pushes keep coming: the output register
		// stays full, the input stalls, and afterwards the queue runs full.
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		hold_go <= 1'b1;
		repeat (24)
			offer_item(spq_pkg::ACT_PUSH, pick_priority(), 16'($urandom));
		run_mix(346);
		in_valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);

		$display("Covered %0d pushes (%0d turned away on a full queue) and %0d pops",
			push_total, reject_total, pop_total);
		$display("(%0d on an empty queue); peak occupancy %0d of %0d, %0d mismatches.",
			empty_pop_total, peak_held, DEPTH, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
